// File: hdl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  // Bus reset: SCL pulses sent before the closing stop
  localparam int unsigned ResetClocks = 9;

  localparam int unsigned TickW = 3;
  localparam int unsigned BitW  = 4;
  localparam int unsigned ByteW = 8;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Bits in a byte; the slot after the last data bit is the ack slot
  localparam logic [BitW-1:0] BitsPerByte = BitW'(ByteW);
  localparam logic [BitW:0]   ResetLast   = (BitW+1)'(ResetClocks);

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_RESET = 3'd5
  } op_t;

  typedef struct packed {
    logic             ack_seen;
    logic [ByteW-1:0] rx_byte;
    logic             cmd_done;
    logic             busy_res;
    logic             sda_release;
    logic             scl_out;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/i2c_master_byte_engine.sv
`default_nettype none

// Channel   Dir  Word bits (low to high)
// --------  ---  ------------------------------------------------------------
// s_*       in   action[2:0] tx_byte[10:3] ack_bit[11] sda_in[12], pad to 16
// m_*       out  scl_out[0] sda_release[1] busy_res[2] cmd_done[3]
//                rx_byte[11:4] ack_seen[12], pad to 16
//
// One input word is one bus tick. The bus state advances in the same
// cycle the word is accepted; its result is registered into the output register,
// or into the skid register when that is stuck, so one word per clock is sustained while s_tready stays high.
// A skid register behind the output register keeps s_tready high while one
// result waits; s_tready drops only when both hold a word.
// rst is synchronous: the engine goes idle with SCL and SDA released and both
// output registers empty.
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  // action[2:0], tx_byte[10:3], ack_bit[11], sda_in[12], zeros above
  input  wire [InDataW-1:0]   s_tdata,
  output logic                m_tvalid,
  input  wire                 m_tready,
  // scl_out[0], sda_release[1], busy_res[2], cmd_done[3], rx_byte[11:4],
  // ack_seen[12], zeros above
  output logic [OutDataW-1:0] m_tdata
);

  // Bus engine state
  op_t              op, op_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic [BitW-1:0]  bit_count, bit_count_next;
  logic [ByteW-1:0] tx_shift, tx_shift_next;
  logic [ByteW-1:0] rx_shift, rx_shift_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;
  logic             ack_level, ack_level_next;
  logic             busy, done;

  // Output and skid registers
  res_t out_word, skid_word, res;
  logic out_valid, skid_valid;

  logic [2:0]       action;
  logic [ByteW-1:0] tx_byte;
  logic             ack_bit, sda_in;
  logic             accept, take;

  assign action  = s_tdata[2:0];
  assign tx_byte = s_tdata[10:3];
  assign ack_bit = s_tdata[11];
  assign sda_in  = s_tdata[12];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;

  // Next bus state for one tick
  always_comb begin
    logic last;
    logic slot_end;
    last            = 1'b0;
    slot_end        = 1'b0;
    op_next         = op;
    tick_count_next = tick_count;
    bit_count_next  = bit_count;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_level_next  = ack_level;
    busy            = 1'b0;

    // Latch a new command only while idle; codes six and seven drop
    if (op == OP_IDLE && action >= 3'(OP_START) && action <= 3'(OP_RESET)) begin
      op_next         = op_t'(action);
      tick_count_next = '0;
      bit_count_next  = '0;
      if (op_t'(action) == OP_WRITE) begin
        tx_shift_next = tx_byte;
      end
      if (op_t'(action) == OP_READ) begin
        tx_shift_next = ByteW'(ack_bit);
        rx_shift_next = '0;
      end
    end

    if (op_next != OP_IDLE) begin
      busy = 1'b1;
      unique case (op_next)
        OP_START: begin
          if (tick_count_next == 3'd1) begin
            sda_level_next = 1'b1;
          end else if (tick_count_next == 3'd2) begin
            scl_level_next = 1'b1;
          end else if (tick_count_next >= 3'd3) begin
            sda_level_next = 1'b0;
            last = 1'b1;
          end
        end
        OP_STOP: begin
          if (tick_count_next == 3'd0) begin
            scl_level_next = 1'b0;
          end else if (tick_count_next == 3'd1) begin
            sda_level_next = 1'b0;
          end else if (tick_count_next == 3'd2) begin
            scl_level_next = 1'b1;
          end else begin
            sda_level_next = 1'b1;
            last = 1'b1;
          end
        end
        OP_WRITE: begin
          if (bit_count_next < BitsPerByte) begin
            if (tick_count_next == 3'd0) begin
              scl_level_next = 1'b0;
            end else if (tick_count_next == 3'd1) begin
              sda_level_next = tx_shift_next[ByteW-1];
            end else if (tick_count_next == 3'd2) begin
              scl_level_next = 1'b1;
            end else begin
              tx_shift_next = {tx_shift_next[ByteW-2:0], 1'b0};
              slot_end = 1'b1;
            end
          end else begin
            if (tick_count_next == 3'd0) begin
              scl_level_next = 1'b0;
            end else if (tick_count_next == 3'd1) begin
              sda_level_next = 1'b1;
            end else if (tick_count_next == 3'd2) begin
              scl_level_next = 1'b1;
            end else if (tick_count_next == 3'd3) begin
              ack_level_next = sda_in;
            end else begin
              scl_level_next = 1'b0;
              last = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (bit_count_next < BitsPerByte) begin
            if (tick_count_next == 3'd0) begin
              scl_level_next = 1'b0;
              sda_level_next = 1'b1;
            end else if (tick_count_next == 3'd1) begin
              scl_level_next = 1'b1;
              rx_shift_next  = {rx_shift_next[ByteW-2:0], sda_in};
            end else begin
              slot_end = 1'b1;
            end
          end else begin
            if (tick_count_next == 3'd0) begin
              scl_level_next = 1'b0;
            end else if (tick_count_next == 3'd1) begin
              sda_level_next = tx_shift_next[0];
            end else if (tick_count_next == 3'd2) begin
              scl_level_next = 1'b1;
            end else if (tick_count_next >= 3'd4) begin
              scl_level_next = 1'b0;
              last = 1'b1;
            end
          end
        end
        OP_RESET: begin
          if (tick_count_next == 3'd0) begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b1;
          end else if (tick_count_next == 3'd2) begin
            scl_level_next = 1'b1;
          end else if (tick_count_next >= 3'd3) begin
            slot_end = 1'b1;
          end
        end
        default: begin
          slot_end = 1'b0;
        end
      endcase

      if (op_next == OP_RESET && slot_end &&
          ({1'b0, bit_count_next} + 1'b1) >= ResetLast) begin
        // Reset clocks done: hand over to a stop
        op_next         = OP_STOP;
        tick_count_next = '0;
        bit_count_next  = '0;
      end else if (last) begin
        op_next         = OP_IDLE;
        tick_count_next = '0;
        bit_count_next  = '0;
      end else if (slot_end) begin
        tick_count_next = '0;
        bit_count_next  = bit_count_next + 1'b1;
      end else begin
        tick_count_next = tick_count_next + 1'b1;
      end
    end
    done = last;
  end

  always_comb begin
    res.scl_out     = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = busy;
    res.cmd_done    = done;
    res.rx_byte     = rx_shift_next;
    res.ack_seen    = ack_level_next;
  end

  // Advance the bus state on every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_IDLE;
      tick_count <= '0;
      bit_count  <= '0;
      tx_shift   <= '0;
      rx_shift   <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_level  <= 1'b0;
    end else if (accept) begin
      op         <= op_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_level  <= ack_level_next;
    end
  end

  // Output register with skid: park a result in skid only when out is stuck
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || take) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end else if (take && skid_valid) begin
      out_word <= skid_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, out_word};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> m_tdata[2])
    else $error("cmd_done reported on a tick that is not busy");

  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    (op == OP_IDLE) |-> (tick_count == '0 && bit_count == '0))
    else $error("idle engine left nonzero tick or bit count");
`endif

endmodule

`default_nettype wire

// File: tb/i2c_master_byte_engine_tb.sv
`default_nettype none

module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  // Action codes outside the command set; the engine must ignore them when idle
  localparam logic [2:0] ActUnused6 = 3'd6;
  localparam logic [2:0] ActUnused7 = 3'd7;

  // How the sender picks sda_in for the ticks of a command
  localparam int SdaLow  = 0;
  localparam int SdaHigh = 1;
  localparam int SdaRand = 2;

  localparam int unsigned MaxGap      = 12;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TargetBusy  = 1500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ResW        = $bits(res_t);

  // One input word, action in the low bits as on s_tdata
  typedef struct packed {
    logic             sda_in;
    logic             ack_bit;
    logic [ByteW-1:0] tx_byte;
    logic [2:0]       action;
  } tick_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // action[2:0], tx_byte[10:3], ack_bit[11], sda_in[12], zeros above
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // scl_out[0], sda_release[1], busy_res[2], cmd_done[3], rx_byte[11:4],
  // ack_seen[12], zeros above
  logic [OutDataW-1:0] m_tdata;

  i2c_master_byte_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus engine predictor: its own copy of the command state
  // ---------------------------------------------------------------------------
  op_t              cur_op;
  logic [5:0]       tick_n;
  logic [BitW-1:0]  bit_n;
  logic [ByteW-1:0] tx_sh;
  logic [ByteW-1:0] rx_sh;
  logic             scl_q;
  logic             sda_q;
  logic             ack_q;

  task automatic reset_bus_model();
    cur_op = OP_IDLE;
    tick_n = '0;
    bit_n  = '0;
    tx_sh  = '0;
    rx_sh  = '0;
    scl_q  = 1'b1;
    sda_q  = 1'b1;
    ack_q  = 1'b0;
  endtask

  // Advance the bus by one tick and return the levels it shows
  function automatic res_t predict_tick(logic [2:0] act, logic [ByteW-1:0] txb,
                                        logic ackb, logic sda_in);
    res_t r;
    logic last;
    logic slot_end;
    logic to_stop;
    logic busy;
    last = 1'b0;
    slot_end = 1'b0;
    to_stop = 1'b0;
    busy = 1'b0;
    // Latch a command only while idle; codes six and seven fall through
    if (cur_op == OP_IDLE && act >= OP_START && act <= OP_RESET) begin
      cur_op = op_t'(act);
      tick_n = '0;
      bit_n  = '0;
      if (act == OP_WRITE) tx_sh = txb;
      if (act == OP_READ) begin
        tx_sh = {{(ByteW-1){1'b0}}, ackb};
        rx_sh = '0;
      end
    end
    if (cur_op != OP_IDLE) begin
      busy = 1'b1;
      case (cur_op)
        OP_START: begin
          if (tick_n == 1) sda_q = 1'b1;
          else if (tick_n == 2) scl_q = 1'b1;
          else if (tick_n >= 3) begin
            sda_q = 1'b0;
            last = 1'b1;
          end
        end
        OP_STOP: begin
          if (tick_n == 0) scl_q = 1'b0;
          else if (tick_n == 1) sda_q = 1'b0;
          else if (tick_n == 2) scl_q = 1'b1;
          else begin
            sda_q = 1'b1;
            last = 1'b1;
          end
        end
        OP_WRITE: begin
          if (bit_n < ByteW) begin
            if (tick_n == 0) scl_q = 1'b0;
            else if (tick_n == 1) sda_q = tx_sh[ByteW-1];
            else if (tick_n == 2) scl_q = 1'b1;
            else begin
              tx_sh = tx_sh << 1;
              slot_end = 1'b1;
            end
          end else begin
            // Ack slot: release SDA and sample the receiver's answer
            if (tick_n == 0) scl_q = 1'b0;
            else if (tick_n == 1) sda_q = 1'b1;
            else if (tick_n == 2) scl_q = 1'b1;
            else if (tick_n == 3) ack_q = sda_in;
            else begin
              scl_q = 1'b0;
              last = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (bit_n < ByteW) begin
            if (tick_n == 0) begin
              scl_q = 1'b0;
              sda_q = 1'b1;
            end else if (tick_n == 1) begin
              scl_q = 1'b1;
              rx_sh = {rx_sh[ByteW-2:0], sda_in};
            end else slot_end = 1'b1;
          end else begin
            // Drive the latched ack level, kept in the low bit of the shifter
            if (tick_n == 0) scl_q = 1'b0;
            else if (tick_n == 1) sda_q = tx_sh[0];
            else if (tick_n == 2) scl_q = 1'b1;
            else if (tick_n >= 4) begin
              scl_q = 1'b0;
              last = 1'b1;
            end
          end
        end
        OP_RESET: begin
          if (tick_n == 0) begin
            scl_q = 1'b0;
            sda_q = 1'b1;
          end else if (tick_n == 2) scl_q = 1'b1;
          else if (tick_n >= 3) begin
            if (int'(bit_n) + 1 >= ResetClocks) to_stop = 1'b1;
            else slot_end = 1'b1;
          end
        end
        default: ;
      endcase
      if (to_stop) begin
        // Hand over to a stop on the next tick, no done pulse yet
        cur_op = OP_STOP;
        tick_n = '0;
        bit_n  = '0;
      end else if (last) begin
        cur_op = OP_IDLE;
        tick_n = '0;
        bit_n  = '0;
      end else if (slot_end) begin
        tick_n = '0;
        bit_n  = bit_n + 1'b1;
      end else begin
        tick_n = tick_n + 1'b1;
      end
    end
    r.scl_out     = scl_q;
    r.sda_release = sda_q;
    r.busy_res    = busy;
    r.cmd_done    = last;
    r.rx_byte     = rx_sh;
    r.ack_seen    = ack_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  res_t        pending_ticks[$];
  int unsigned err_n = 0;
  int unsigned checked_n = 0;
  int unsigned busy_words = 0;
  int unsigned cmd_n[8];
  int unsigned cycle_n = 0;

  // Sender pacing: stretches of random gaps alternate with stretches of none
  bit          src_calm = 1'b0;
  int unsigned src_left = 0;
  bit          src_rush = 1'b0;

  // Long hold-off request for the receiver, consumed by its own process
  int unsigned sink_hold = 0;

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    err_n++;
    if (err_n <= 40)
      $display("mismatch on result word %0d: %s got 0x%0h, want 0x%0h",
               checked_n, field, got, want);
  endtask

  // Offer one word after a random gap, wait for the handshake, then predict it
  task automatic send_word(input tick_word_t w, output res_t r);
    int unsigned gap;
    if (src_left == 0) begin
      src_calm = ($urandom_range(0, 2) == 0);
      src_left = $urandom_range(10, 60);
    end
    src_left--;
    gap = (src_calm || src_rush) ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'(w);
    do @(posedge clk); while (!s_tready);
    r = predict_tick(w.action, w.tx_byte, w.ack_bit, w.sda_in);
    pending_ticks.push_back(r);
    if (r.busy_res) busy_words++;
  endtask

  function automatic logic pick_sda(int sda_pick);
    if (sda_pick == SdaLow) return 1'b0;
    if (sda_pick == SdaHigh) return 1'b1;
    return 1'(($urandom_range(0, 1)));
  endfunction

  // Issue one command while idle, then feed ticks until its done pulse.
  // Busy ticks carry random payload and now and then a random action; noisy ones always do.
  task automatic run_command(op_t op, logic [ByteW-1:0] txb, logic ackb,
                             int sda_pick, bit noisy);
    tick_word_t w;
    res_t       r;
    w.action  = op;
    w.tx_byte = txb;
    w.ack_bit = ackb;
    w.sda_in  = pick_sda(sda_pick);
    cmd_n[op]++;
    send_word(w, r);
    while (!r.cmd_done) begin
      w.action  = (noisy || $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_IDLE;
      w.tx_byte = ByteW'($urandom);
      w.ack_bit = 1'($urandom_range(0, 1));
      w.sda_in  = pick_sda(sda_pick);
      send_word(w, r);
    end
  endtask

  task automatic send_idle_word(logic [2:0] act);
    tick_word_t w;
    res_t       r;
    w.action  = act;
    w.tx_byte = ByteW'($urandom);
    w.ack_bit = 1'($urandom_range(0, 1));
    w.sda_in  = 1'($urandom_range(0, 1));
    send_word(w, r);
  endtask

  // Drop s_tvalid, hold until every result is back, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_codes();
    // None and the two unused codes must leave the engine idle
    send_idle_word(OP_IDLE);
    send_idle_word(ActUnused6);
    send_idle_word(ActUnused7);
    send_idle_word(OP_IDLE);
  endtask

  task automatic test_start_stop();
    run_command(OP_START, 8'h00, 1'b0, SdaRand, 1'b0);
    run_command(OP_STOP,  8'hFF, 1'b1, SdaRand, 1'b0);
    run_command(OP_STOP,  8'h00, 1'b0, SdaRand, 1'b0);
    run_command(OP_START, 8'hFF, 1'b1, SdaRand, 1'b0);
  endtask

  task automatic test_write_extremes();
    run_command(OP_WRITE, 8'h00, 1'b1, SdaLow,  1'b0);
    run_command(OP_WRITE, 8'hFF, 1'b0, SdaHigh, 1'b0);
    run_command(OP_WRITE, 8'hA5, 1'b0, SdaRand, 1'b0);
  endtask

  task automatic test_read_extremes();
    run_command(OP_READ, 8'h00, 1'b0, SdaHigh, 1'b0);
    run_command(OP_READ, 8'hFF, 1'b1, SdaLow,  1'b0);
    run_command(OP_READ, 8'h5A, 1'b1, SdaRand, 1'b0);
  endtask

  task automatic test_bus_reset();
    run_command(OP_RESET, 8'hFF, 1'b1, SdaLow, 1'b0);
    run_command(OP_START, 8'h00, 1'b0, SdaRand, 1'b0);
    run_command(OP_RESET, 8'h00, 1'b0, SdaHigh, 1'b0);
  endtask

  task automatic test_busy_ignore();
    // Every busy tick carries a random action; none may disturb the command
    run_command(OP_WRITE, ByteW'($urandom), 1'b0, SdaRand, 1'b1);
    run_command(OP_READ,  ByteW'($urandom), 1'b1, SdaRand, 1'b1);
    run_command(OP_RESET, ByteW'($urandom), 1'b0, SdaRand, 1'b1);
  endtask

  task automatic random_command();
    int unsigned pick;
    int unsigned idle_n;
    op_t         op;
    // Now and then sprinkle idle words, some with unused codes
    idle_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (idle_n) begin
      pick = $urandom_range(0, 2);
      send_idle_word(pick == 0 ? ActUnused6 : pick == 1 ? ActUnused7 : OP_IDLE);
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) op = OP_START;
    else if (pick < 40) op = OP_STOP;
    else if (pick < 65) op = OP_WRITE;
    else if (pick < 90) op = OP_READ;
    else op = OP_RESET;
    run_command(op, ByteW'($urandom), 1'($urandom_range(0, 1)), SdaRand, 1'b0);
  endtask

  task automatic test_random_traffic();
    // Mostly start, bytes, stop in order, with stray commands mixed in
    while (busy_words < TargetBusy) begin
      if ($urandom_range(0, 4) != 0) begin
        run_command(OP_START, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0)
            run_command(OP_WRITE, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
          else
            run_command(OP_READ, ByteW'($urandom), 1'($urandom_range(0, 1)), SdaRand, 1'b0);
        end
        run_command(OP_STOP, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
      end else begin
        random_command();
      end
    end
  endtask

  task automatic test_backpressure();
    // Receiver stalls for a long stretch while the sender pushes back to back
    src_rush = 1'b1;
    sink_hold = HoldCycles;
    run_command(OP_WRITE, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
    run_command(OP_READ,  ByteW'($urandom), 1'b1, SdaRand, 1'b0);
    src_rush = 1'b0;
  endtask

  task automatic test_source_pause();
    run_command(OP_START, 8'h00, 1'b0, SdaRand, 1'b0);
    wait_drained();
    run_command(OP_WRITE, ByteW'($urandom), 1'b0, SdaRand, 1'b0);
    wait_drained();
    run_command(OP_STOP, 8'h00, 1'b0, SdaRand, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, with one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    bit          calm;
    int unsigned left;
    calm = 1'b0;
    left = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (left == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        left = $urandom_range(10, 60);
      end
      left--;
      gap = calm ? 0 : $urandom_range(0, MaxGap);
      if (sink_hold != 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[ResW-1:0]);
      if (pending_ticks.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        want = pending_ticks.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch("scl_out", got.scl_out, want.scl_out);
        if (got.sda_release !== want.sda_release)
          report_mismatch("sda_release", got.sda_release, want.sda_release);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.cmd_done !== want.cmd_done)
          report_mismatch("cmd_done", got.cmd_done, want.cmd_done);
        if (got.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_seen !== want.ack_seen)
          report_mismatch("ack_seen", got.ack_seen, want.ack_seen);
        if (m_tdata[OutDataW-1:ResW] !== '0)
          report_mismatch("pad bits", m_tdata[OutDataW-1:ResW], 0);
      end
      checked_n++;
    end
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_n, pending_ticks.size());
      $display("i2c_master_byte_engine_tb NOT OK");
      $finish;
    end
  end

  initial begin
    reset_bus_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_codes();
    test_start_stop();
    test_write_extremes();
    test_read_extremes();
    test_bus_reset();
    test_busy_ignore();
    test_random_traffic();
    test_backpressure();
    test_source_pause();
    wait_drained();
    $display("commands: start %0d, stop %0d, write %0d, read %0d, bus reset %0d",
             cmd_n[OP_START], cmd_n[OP_STOP], cmd_n[OP_WRITE], cmd_n[OP_READ],
             cmd_n[OP_RESET]);
    $display("%0d busy ticks among %0d result words checked, %0d mismatches",
             busy_words, checked_n, err_n);
    if (err_n == 0)
      $display("i2c_master_byte_engine_tb OK");
    else
      $display("i2c_master_byte_engine_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
